FILE: rtl/lbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBP 3x3 package
// Request and result types, register indexes and fixed constants shared by
// the 3x3 local binary pattern stream unit.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIXEL_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  // One more bit than the height so the row count can pass the last row.
  localparam int ROW_W      = CFG_HEIGHT_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN   = 16'd2;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [PIXEL_W-1:0] pixel;
  } lbp_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] code;
    logic               frame_end;
  } lbp_out_t;

endpackage

FILE: rtl/lbp_3x3_pixel_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBP 3x3 pixel stream unit
// Computes the 8-bit local binary pattern of each raster pixel using two
// line stores and a 3x3 window.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the in_ channel (valid/ready) in raster order, one
// request per pixel; a request with mode set is a flush that advances the
// raster position without new data. Codes leave on the out_ channel, one per
// pixel, with frame_end set on the last pixel of the frame. Frame size comes
// from the cfg_ write port; the user must see that it is changed only while
// the block is idle, which the block itself does not enforce. The code of a
// pixel is produced when the request W+1 positions later is accepted. Throughput:
// one request per clock while in_ready is high. Each request does one read of
// both line stores at the column address, in the following cycle the write-back
// and window shift, so the single read and write port of each store sets the rate.
// Reset clears the raster position, the window and the result buffer; the
// line stores are not cleared and need no clearing pass. When the receiver
// stalls, a three-entry result buffer absorbs the requests in flight and
// in_ready drops once it cannot take more.
// ----------------------------------------------------------------------------
module lbp_3x3_pixel_stream_unit
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lbp_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lbp_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EWW     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (EWW > CFG_WIDTH_W) ? EWW : CFG_WIDTH_W;
  localparam int FIFO_D  = 3;
  localparam int PTR_W   = 2;
  localparam int CNT_W   = 2;

  // Configuration registers.
  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata;
      endcase
    end
  end

  // Effective width and height minus one, after clamping.
  logic [CMP_W-1:0]        width_ext;
  logic [COL_W-1:0]        w_m1;
  logic [CFG_HEIGHT_W-1:0] h_m1;

  always_comb begin
    width_ext = CMP_W'(cfg_width_r);
    if (width_ext < CMP_W'(2)) begin
      w_m1 = COL_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(width_ext - CMP_W'(1));
    end
    if (cfg_height_r < HEIGHT_MIN) begin
      h_m1 = CFG_HEIGHT_W'(1);
    end else begin
      h_m1 = cfg_height_r - CFG_HEIGHT_W'(1);
    end
  end

  // Handshake and result buffer occupancy.
  logic             s1_valid_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic [CNT_W:0]   in_flight;
  logic             in_fire;
  logic             out_fire;

  assign in_flight = {1'b0, fifo_cnt_r} + {{CNT_W{1'b0}}, s1_valid_r};
  assign in_ready  = in_flight < (CNT_W+1)'(FIFO_D);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = fifo_cnt_r != '0;
  assign out_fire  = out_valid && out_ready;

  // Stage 0: raster position and neighbour availability of the centre.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             emit;
  logic [ROW_W-1:0] cr;
  logic [COL_W-1:0] cc;
  logic             nb_a, nb_b, nb_l, nb_rt, last;

  always_comb begin
    emit = (row_r > ROW_W'(1)) || (row_r == ROW_W'(1) && col_r != '0);
    // The centre sits one item back, which at column zero is the previous row end.
    if (col_r == '0) begin
      cr = row_r - ROW_W'(2);
      cc = w_m1;
    end else begin
      cr = row_r - ROW_W'(1);
      cc = col_r - COL_W'(1);
    end
    nb_a  = cr != '0;
    nb_b  = cr < ROW_W'(h_m1);
    nb_l  = cc != '0;
    nb_rt = cc < w_m1;
    last  = (cr >= ROW_W'(h_m1)) && (cc >= w_m1);
    if (emit && last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_r >= w_m1) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: one read per request, write-back in the following cycle.
  logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] up_rd_r;
  logic [PIXEL_W-1:0] mid_rd_r;

  // Stage 1 payload registers.
  logic [COL_W-1:0]   s1_addr_r;
  logic [PIXEL_W-1:0] s1_px_r;
  logic               s1_emit_r;
  logic               s1_a_r, s1_b_r, s1_l_r, s1_rt_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      // The request right after a frame end reads the column still being written back.
      if (s1_valid_r && s1_addr_r == col_r) begin
        up_rd_r  <= mid_rd_r;
        mid_rd_r <= s1_px_r;
      end else begin
        up_rd_r  <= upper_mem[col_r];
        mid_rd_r <= middle_mem[col_r];
      end
      s1_addr_r <= col_r;
      s1_px_r   <= (in_data.mode == MODE_FLUSH) ? '0 : in_data.pixel;
      s1_emit_r <= emit;
      s1_a_r    <= nb_a;
      s1_b_r    <= nb_b;
      s1_l_r    <= nb_l;
      s1_rt_r   <= nb_rt;
      s1_last_r <= last;
    end
    if (s1_valid_r) begin
      upper_mem[s1_addr_r]  <= mid_rd_r;
      middle_mem[s1_addr_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  // Stage 1: window shift and code.
  logic [PIXEL_W-1:0] win_r [3][3];
  logic [PIXEL_W-1:0] wn [3][3];
  logic [PIXEL_W-1:0] ctr;
  logic [PIXEL_W-1:0] code;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wn[r][0] = win_r[r][1];
      wn[r][1] = win_r[r][2];
    end
    wn[0][2] = up_rd_r;
    wn[1][2] = mid_rd_r;
    wn[2][2] = s1_px_r;
    ctr = wn[1][1];
    code[0] = s1_a_r && s1_l_r  && (wn[0][0] >= ctr);
    code[1] = s1_a_r            && (wn[0][1] >= ctr);
    code[2] = s1_a_r && s1_rt_r && (wn[0][2] >= ctr);
    code[3] = s1_l_r            && (wn[1][0] >= ctr);
    code[4] = s1_rt_r           && (wn[1][2] >= ctr);
    code[5] = s1_b_r && s1_l_r  && (wn[2][0] >= ctr);
    code[6] = s1_b_r            && (wn[2][1] >= ctr);
    code[7] = s1_b_r && s1_rt_r && (wn[2][2] >= ctr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_valid_r) begin
      win_r <= wn;
    end
  end

  // Result buffer.
  lbp_out_t         fifo_r [FIFO_D];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic             push;

  assign push     = s1_valid_r && s1_emit_r;
  assign out_data = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{code: code, frame_end: s1_last_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_D - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_D - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !out_fire) begin
        fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
      end else if (!push && out_fire) begin
        fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LBP 3x3 pixel stream unit testbench
// Streams raster frames of several sizes through the unit, predicts every
// pattern code from its own line stores and 3x3 neighborhood, and compares
// each code and frame_end flag in order. It covers drain with flush and
// late pixel requests, width and height clamping, and height changes made
// in the middle of a frame.
// ----------------------------------------------------------------------------
module testbench;
  import lbp_pkg::*;

  localparam int LINE_DEPTH = 1024;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lbp_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lbp_out_t out_data;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lbp_3x3_pixel_stream_unit #(
    .MAX_WIDTH (LINE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the frame geometry and the pixel history.
  logic [CFG_WIDTH_W-1:0]  shadow_width;
  logic [CFG_HEIGHT_W-1:0] shadow_height;
  logic [PIXEL_W-1:0] upper_row [LINE_DEPTH];
  logic [PIXEL_W-1:0] middle_row [LINE_DEPTH];
  logic [PIXEL_W-1:0] nbhd [3][3];
  int unsigned pos_col;
  int unsigned pos_row;
  bit          frame_closed;

  lbp_out_t expected_codes[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count = 0;
  int items_sent;
  int codes_checked = 0;
  int frames_done;

  always #5 clk = ~clk;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(shadow_width);
    if (w < 2) w = 2;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (shadow_height < HEIGHT_MIN) ? 32'(HEIGHT_MIN) : 32'(shadow_height);
  endfunction

  // Advances the shadow raster by one request and queues the code it releases.
  function automatic void predict_lbp(input lbp_in_t req);
    int unsigned w, h, col, idx, cr, cc;
    logic [PIXEL_W-1:0] px, ctr;
    logic nb_up, nb_down, nb_left, nb_right, last;
    lbp_out_t res;
    w = eff_width();
    h = eff_height();
    col = pos_col;
    idx = (col < LINE_DEPTH) ? col : 0;
    px = (req.mode == MODE_FLUSH) ? '0 : req.pixel;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = upper_row[idx];
    nbhd[1][2] = middle_row[idx];
    nbhd[2][2] = px;
    upper_row[idx] = middle_row[idx];
    middle_row[idx] = px;

    if (pos_row >= 2 || (pos_row == 1 && col >= 1)) begin
      // The centre sits one position behind, wrapping to the previous row end.
      if (col >= 1) begin
        cr = pos_row - 1;
        cc = col - 1;
      end else begin
        cr = pos_row - 2;
        cc = w - 1;
      end
      nb_up    = cr > 0;
      nb_down  = cr < h - 1;
      nb_left  = cc > 0;
      nb_right = cc < w - 1;
      ctr = nbhd[1][1];
      res.code = {nb_down && nb_right && nbhd[2][2] >= ctr,
                  nb_down && nbhd[2][1] >= ctr,
                  nb_down && nb_left && nbhd[2][0] >= ctr,
                  nb_right && nbhd[1][2] >= ctr,
                  nb_left && nbhd[1][0] >= ctr,
                  nb_up && nb_right && nbhd[0][2] >= ctr,
                  nb_up && nbhd[0][1] >= ctr,
                  nb_up && nb_left && nbhd[0][0] >= ctr};
      last = (cr >= h - 1) && (cc >= w - 1);
      res.frame_end = last;
      expected_codes.push_back(res);
      if (last) begin
        pos_col = 0;
        pos_row = 0;
        frame_closed = 1'b1;
        frames_done++;
        return;
      end
    end
    pos_col = col + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
  endfunction

  function automatic lbp_in_t make_req(input logic mode, input logic [PIXEL_W-1:0] pixel);
    lbp_in_t req;
    req.mode = mode;
    req.pixel = pixel;
    return req;
  endfunction

  // Half the pixels sit close to a per-frame level so that ties are common.
  function automatic logic [PIXEL_W-1:0] pick_pixel(input int base);
    if ($urandom_range(1) == 0) return PIXEL_W'($urandom_range(255));
    return PIXEL_W'(base + $urandom_range(2));
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  task automatic send_request(input lbp_in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_lbp(req);
    items_sent++;
  endtask

  // Holds off the sender until every expected code is out, then lets the
  // last requests that produce no code settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    if (idx == CFG_IMAGE_WIDTH) shadow_width = CFG_WIDTH_W'(value);
    else shadow_height = CFG_HEIGHT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_pixels(input int count);
    int base;
    base = $urandom_range(253);
    repeat (count) send_request(make_req(MODE_PIXEL, pick_pixel(base)));
  endtask

  // Fills the rest of the frame, then drains it with a mix of flush requests
  // and late pixel requests until the code with frame_end has been predicted.
  task automatic send_until_frame_end(input int noise_pct);
    int base;
    lbp_in_t req;
    base = $urandom_range(253);
    frame_closed = 1'b0;
    do begin
      if (pos_row < eff_height()) begin
        if ($urandom_range(99) < noise_pct) begin
          req = make_req(MODE_FLUSH, PIXEL_W'($urandom_range(255)));
        end else begin
          req = make_req(MODE_PIXEL, pick_pixel(base));
        end
      end else begin
        req = make_req($urandom_range(1) ? MODE_FLUSH : MODE_PIXEL,
                       PIXEL_W'($urandom_range(255)));
      end
      send_request(req);
    end while (!frame_closed);
  endtask

  task automatic test_directed_frames();
    logic [PIXEL_W-1:0] frame_3x3 [9];
    set_idling(0, 0);
    // Width 1 and height 0 both clamp to the 2x2 minimum.
    set_geometry(1, 0);
    send_request(make_req(MODE_PIXEL, 8'd128));
    send_request(make_req(MODE_PIXEL, 8'd255));
    send_request(make_req(MODE_PIXEL, 8'd0));
    send_request(make_req(MODE_PIXEL, 8'd128));
    send_request(make_req(MODE_FLUSH, 8'd77));
    send_request(make_req(MODE_PIXEL, 8'hAA));
    send_request(make_req(MODE_FLUSH, 8'd0));

    set_geometry(3, 3);
    frame_3x3 = '{8'd255, 8'd0, 8'd255, 8'h55, 8'h55, 8'hAA, 8'd0, 8'h55, 8'd255};
    foreach (frame_3x3[i]) send_request(make_req(MODE_PIXEL, frame_3x3[i]));
    send_request(make_req(MODE_PIXEL, 8'hFF));
    send_request(make_req(MODE_FLUSH, 8'hFF));
    send_request(make_req(MODE_FLUSH, 8'd0));
    send_request(make_req(MODE_PIXEL, 8'd0));
  endtask

  task automatic test_random_frames();
    int sender_pct [4] = '{0, 45, 0, 12};
    int receiver_pct [4] = '{0, 0, 45, 12};
    int start;
    int unsigned w, h;
    for (int p = 0; p < 4; p++) begin
      set_idling(sender_pct[p], receiver_pct[p]);
      start = items_sent;
      while (items_sent - start < 200) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 2);
        h = ($urandom_range(5) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 2);
        set_geometry(w, h);
        send_until_frame_end(4);
      end
    end
  endtask

  task automatic test_size_clamping();
    set_idling(12, 12);
    set_geometry(0, 1);
    send_until_frame_end(0);
    set_geometry(1, 5);
    send_until_frame_end(10);
  endtask

  task automatic test_height_change_mid_frame();
    set_idling(12, 12);
    // Height drops to the row in progress: its row end closes the frame.
    set_geometry(40, 65535);
    send_pixels(2 * 40 + 15);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_until_frame_end(0);

    // Height drops below the rows already seen.
    set_geometry(3, 65535);
    send_pixels(15);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_until_frame_end(0);

    // Height rises past the current row and the frame ends normally.
    set_geometry(5, 65535);
    send_pixels(20);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 9);
    send_until_frame_end(3);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_codes
    lbp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: code %0d frame_end %0b arrived with none expected",
                   out_data.code, out_data.frame_end);
      end else begin
        want = expected_codes.pop_front();
        codes_checked++;
        if (out_data.code !== want.code || out_data.frame_end !== want.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: code exp %0d got %0d, frame_end exp %0b got %0b",
                     want.code, out_data.code, want.frame_end, out_data.frame_end);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    shadow_width = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (middle_row[i]) middle_row[i] = '0;
    foreach (nbhd[r, c]) nbhd[r][c] = '0;
    pos_col = 0;
    pos_row = 0;
    frame_closed = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    frames_done = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames();
    test_size_clamping();
    test_height_change_mid_frame();

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests and checked %0d codes over %0d frames,", items_sent,
             codes_checked, frames_done);
    $display("widths 2 to 40, clamped sizes and height changes inside a frame.");
    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching codes, %0d codes never seen", mismatch_count,
               expected_codes.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d codes outstanding", expected_codes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
